FILE: hw/rtl/y2r_pkg.sv
// y2r_pkg: shared sizes, register indexes, coefficients and the stage payload type
// of the 4:2:0 YCbCr to RGB converter with flipped destination address.
// No dependencies.
package y2r_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WEFF_W     = COL_W + 1;
  localparam int HEFF_W     = ROW_W + 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int COL3_W     = COL_W + 2;
  localparam int ROFF_W     = ROW_W + 2;

  // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;
  localparam int FWIDTH_W  = 12;
  localparam int FHEIGHT_W = 12;
  localparam int STRIDE_W  = 13;
  localparam int ADDR_W    = 24;
  localparam int PROD_W    = ROFF_W + STRIDE_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 2'd2;

  localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = 12'd640;
  localparam logic [FHEIGHT_W-1:0] FHEIGHT_RST = 12'd480;
  localparam logic [STRIDE_W-1:0]  STRIDE_RST  = 13'd1920;

  // bt.601 studio range coefficients, 16.16 fixed point
  localparam int MUL_W = 27;
  localparam logic signed [MUL_W-1:0] COEF_Y    = 27'sd76309;
  localparam logic signed [MUL_W-1:0] COEF_R_CR = 27'sd104597;
  localparam logic signed [MUL_W-1:0] COEF_G_CB = 27'sd25674;
  localparam logic signed [MUL_W-1:0] COEF_G_CR = 27'sd53278;
  localparam logic signed [MUL_W-1:0] COEF_B_CB = 27'sd132201;
  localparam logic signed [8:0]       LUMA_OFS  = 9'sd16;
  localparam logic signed [8:0]       CHROMA_OFS = 9'sd128;

  // pixel transaction leaving the front stage
  typedef struct packed {
    logic [7:0]               luma;
    logic [15:0]              cbcr;     // cb in 15:8, cr in 7:0
    logic [COL3_W-1:0]        col3;     // column * 3
    logic signed [ROFF_W-1:0] row_off;  // height - 1 - row
    logic                     last;
  } y2r_pix_t;

endpackage

FILE: hw/rtl/y2r_ram.sv
// y2r_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module y2r_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/y2r_front.sv
// y2r_front: raster counters, chroma hold, half-width chroma line buffer and
// the input register stage. Depends on y2r_pkg and y2r_ram.
module y2r_front
  import y2r_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_luma,
  input  logic [7:0]        in_chroma_blue,
  input  logic [7:0]        in_chroma_red,
  input  logic [WEFF_W-1:0] width_eff,
  input  logic [HEFF_W-1:0] height_eff,
  output logic              pix_valid,
  input  logic              pix_ready,
  output y2r_pix_t          pix
);

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [15:0]        hold_r, hold_nxt;
  logic               s1_v_r, s1_v_nxt;
  y2r_pix_t           s1_r;
  logic               s1_line_r;
  logic               accept;
  logic               even_site;
  logic               row_end;
  logic               frame_last;
  logic [15:0]        in_pair;
  logic [15:0]        line_rdata;
  logic [LINE_AW-1:0] slot;
  y2r_pix_t           s1_nxt;

  assign in_ready  = !s1_v_r || pix_ready;
  assign accept    = in_valid && in_ready;
  assign in_pair   = {in_chroma_blue, in_chroma_red};
  assign even_site = !row_r[0] && !col_r[0];
  assign slot      = col_r[COL_W-1:1];

  // end of row and end of frame
  assign row_end    = ({1'b0, col_r} + WEFF_W'(1)) >= width_eff;
  assign frame_last = row_end && (({1'b0, row_r} + HEFF_W'(1)) >= height_eff);

  // counter and hold next values
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    hold_nxt = hold_r;
    if (accept) begin
      if (even_site) begin
        hold_nxt = in_pair;
      end
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // stage one payload
  always_comb begin
    s1_nxt.luma    = in_luma;
    s1_nxt.cbcr    = even_site ? in_pair : hold_r;
    s1_nxt.col3    = {2'b00, col_r} + {1'b0, col_r, 1'b0};
    s1_nxt.row_off = $signed({1'b0, height_eff}) - ROFF_W'(1)
                     - $signed({2'b00, row_r});
    s1_nxt.last    = frame_last;
  end

  assign s1_v_nxt = in_ready ? in_valid : s1_v_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      hold_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      hold_r <= hold_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r      <= s1_nxt;
      s1_line_r <= row_r[0];
    end
  end

  // chroma line for the odd row below
  y2r_ram #(
    .WIDTH (16),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (accept && even_site),
    .waddr (slot),
    .wdata (in_pair),
    .re    (accept && row_r[0]),
    .raddr (slot),
    .rdata (line_rdata)
  );

  // odd rows take chroma from the line buffer
  always_comb begin
    pix      = s1_r;
    pix.cbcr = s1_line_r ? line_rdata : s1_r.cbcr;
  end

  assign pix_valid = s1_v_r;

  // counters wrap to the frame origin after the last pixel
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_last |=> col_r == '0 && row_r == '0)
    else $error("counters did not return to origin at frame end");

  // a sample site loads the hold register
  a_hold_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept && even_site |=> hold_r == $past(in_pair))
    else $error("chroma hold not loaded at sample site");

  // stage one keeps its transaction while the next stage is busy
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !pix_ready |=> s1_v_r && $stable(s1_r))
    else $error("stage one lost a stalled transaction");

endmodule

FILE: hw/rtl/y2r_color.sv
// y2r_color: color matrix products, destination address product, clamping and
// the result register stage. Depends on y2r_pkg.
module y2r_color
  import y2r_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pix_valid,
  output logic                pix_ready,
  input  y2r_pix_t            pix,
  input  logic [STRIDE_W-1:0] row_stride,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic [ADDR_W-1:0]   out_byte_address,
  output logic                out_frame_end
);

  function automatic logic [7:0] clamp8(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  logic                     out_free;
  logic                     s2_free;
  logic                     s2_v_r;
  logic                     out_v_r;
  logic signed [8:0]        y_s, cb_s, cr_s;
  logic signed [MUL_W-1:0]  y_prod, r_prod, g_prod, b_prod;
  logic signed [PROD_W-1:0] a_prod;
  logic signed [9:0]        y_adj_r, b_t_r;
  logic signed [8:0]        r_t_r, g_t_r;
  logic [ADDR_W-1:0]        a_prod_r;
  logic [COL3_W-1:0]        col3_r;
  logic                     last_r;
  logic signed [10:0]       r_sum, g_sum, b_sum;
  logic [7:0]               red_r, green_r, blue_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     end_r;

  // pipeline flow
  assign out_free  = !out_v_r || out_ready;
  assign s2_free   = !s2_v_r || out_free;
  assign pix_ready = s2_free;

  // offsets and products
  assign y_s   = $signed({1'b0, pix.luma}) - LUMA_OFS;
  assign cb_s  = $signed({1'b0, pix.cbcr[15:8]}) - CHROMA_OFS;
  assign cr_s  = $signed({1'b0, pix.cbcr[7:0]}) - CHROMA_OFS;
  assign y_prod = MUL_W'(y_s) * COEF_Y;
  assign r_prod = MUL_W'(cr_s) * COEF_R_CR;
  assign g_prod = MUL_W'(cb_s) * COEF_G_CB + MUL_W'(cr_s) * COEF_G_CR;
  assign b_prod = MUL_W'(cb_s) * COEF_B_CB;
  assign a_prod = PROD_W'(pix.row_off) * $signed(PROD_W'({1'b0, row_stride}));

  // stage two registers, floor shift by 16 is a bit select
  always_ff @(posedge clk) begin
    if (pix_valid && s2_free) begin
      y_adj_r  <= y_prod[25:16];
      r_t_r    <= r_prod[24:16];
      g_t_r    <= g_prod[24:16];
      b_t_r    <= b_prod[25:16];
      a_prod_r <= a_prod[ADDR_W-1:0];
      col3_r   <= pix.col3;
      last_r   <= pix.last;
    end
  end

  // channel sums
  assign r_sum = 11'(y_adj_r) + 11'(r_t_r);
  assign g_sum = 11'(y_adj_r) - 11'(g_t_r);
  assign b_sum = 11'(y_adj_r) + 11'(b_t_r);

  // result registers
  always_ff @(posedge clk) begin
    if (s2_v_r && out_free) begin
      red_r   <= clamp8(r_sum);
      green_r <= clamp8(g_sum);
      blue_r  <= clamp8(b_sum);
      addr_r  <= a_prod_r + ADDR_W'(col3_r);
      end_r   <= last_r;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_v_r <= pix_valid;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_byte_address = addr_r;
  assign out_frame_end    = end_r;

  // backpressure reaches stage one only when both later stages are full
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !pix_ready |-> s2_v_r && out_v_r)
    else $error("stage one stalled with a free stage downstream");

  // stage two keeps its transaction under a stalled result
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_free |=> s2_v_r && $stable(y_adj_r) && $stable(a_prod_r))
    else $error("stage two lost a stalled transaction");

endmodule

FILE: hw/rtl/ycbcr420_to_rgb_flip.sv
// ycbcr420_to_rgb_flip: top level, configuration registers and stage wiring.
// Depends on y2r_pkg, y2r_front and y2r_color.
//
// Converts a 4:2:0 luma stream in raster order to BT.601 studio-range RGB and
// gives each pixel's byte address in a vertically flipped image. One pixel is
// taken per clock while the input is ready; each transaction passes an input
// register, a product register and a result register in that order, and a
// stalled result only stops the input once all three stages hold data. Chroma is
// sampled on even rows at even columns and kept in a 1024-entry line buffer for
// the odd row below.
// Write frame_width, frame_height and row_stride only while no transaction is
// in flight.
module ycbcr420_to_rgb_flip
  import y2r_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_luma,
  input  logic [7:0]           in_chroma_blue,
  input  logic [7:0]           in_chroma_red,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic [ADDR_W-1:0]    out_byte_address,
  output logic                 out_frame_end
);

  logic [FWIDTH_W-1:0]  frame_width_r, frame_width_nxt;
  logic [FHEIGHT_W-1:0] frame_height_r, frame_height_nxt;
  logic [STRIDE_W-1:0]  row_stride_r, row_stride_nxt;
  logic [WEFF_W-1:0]    width_eff;
  logic [HEFF_W-1:0]    height_eff;
  logic                 pix_valid;
  logic                 pix_ready;
  y2r_pix_t             pix;

  // configuration writes
  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    row_stride_nxt   = row_stride_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_data[FHEIGHT_W-1:0];
        REG_ROW_STRIDE:   row_stride_nxt   = cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FWIDTH_RST;
      frame_height_r <= FHEIGHT_RST;
      row_stride_r   <= STRIDE_RST;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      row_stride_r   <= row_stride_nxt;
    end
  end

  // effective sizes, zero means one, oversize clamps to the maximum
  always_comb begin
    if (frame_width_r == '0) begin
      width_eff = WEFF_W'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      width_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      width_eff = WEFF_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      height_eff = HEFF_W'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      height_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      height_eff = HEFF_W'(frame_height_r);
    end
  end

  y2r_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_luma        (in_luma),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .width_eff      (width_eff),
    .height_eff     (height_eff),
    .pix_valid      (pix_valid),
    .pix_ready      (pix_ready),
    .pix            (pix)
  );

  y2r_color u_color (
    .clk              (clk),
    .rst_n            (rst_n),
    .pix_valid        (pix_valid),
    .pix_ready        (pix_ready),
    .pix              (pix),
    .row_stride       (row_stride_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_byte_address (out_byte_address),
    .out_frame_end    (out_frame_end)
  );

endmodule

FILE: tb/tb_ycbcr420_to_rgb_flip.sv
// tb_ycbcr420_to_rgb_flip: self-checking testbench for the 4:2:0 ycbcr to rgb converter
// with flipped destination address; predicts every pixel and checks each result in order.
// Depends on y2r_pkg and ycbcr420_to_rgb_flip.
module tb_ycbcr420_to_rgb_flip;
  import y2r_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 64;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // bt.601 studio range gains, 16.16 fixed point
  localparam int Y_GAIN    = 76309;
  localparam int CR_TO_R   = 104597;
  localparam int CB_TO_G   = 25674;
  localparam int CR_TO_G   = 53278;
  localparam int CB_TO_B   = 132201;
  localparam int Y_FLOOR   = 16;
  localparam int C_CENTER  = 128;

  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [ADDR_W-1:0] addr;
    logic              frame_end;
  } rgb_pixel_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_luma = '0;
  logic [7:0]           in_chroma_blue = '0;
  logic [7:0]           in_chroma_red = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic [ADDR_W-1:0]    out_byte_address;
  logic                 out_frame_end;

  // predicted geometry and stream position
  logic [FWIDTH_W-1:0]  geom_width = FWIDTH_RST;
  logic [FHEIGHT_W-1:0] geom_height = FHEIGHT_RST;
  logic [STRIDE_W-1:0]  geom_stride = STRIDE_RST;
  int unsigned          pred_col = 0;
  int unsigned          pred_row = 0;
  logic [15:0]          pred_hold = '0;
  logic [15:0]          pred_line [LINE_DEPTH];

  rgb_pixel_t expected_pixels [$];

  int src_idle_pct = 31;
  int sink_idle_pct = 46;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  int frames_seen = 0;
  int geometries = 0;
  int errors = 0;
  int input_stall_cycles = 0;
  int cycle_count = 0;

  ycbcr420_to_rgb_flip uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_luma          (in_luma),
    .in_chroma_blue   (in_chroma_blue),
    .in_chroma_red    (in_chroma_red),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_byte_address (out_byte_address),
    .out_frame_end    (out_frame_end)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // pixel predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned eff_width(input logic [FWIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height(input logic [FHEIGHT_W-1:0] h);
    if (h == 0) return 1;
    if (h > MAX_HEIGHT) return MAX_HEIGHT;
    return h;
  endfunction

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // converts one pixel and advances the raster position
  function automatic rgb_pixel_t predict_rgb_pixel(input logic [7:0] y, input logic [7:0] cb,
                                                   input logic [7:0] cr);
    int unsigned w;
    int unsigned h;
    int unsigned slot;
    int unsigned addr;
    logic [15:0] pair;
    int          y_adj;
    int          cb_adj;
    int          cr_adj;
    bit          row_end;
    rgb_pixel_t  px;
    w = eff_width(geom_width);
    h = eff_height(geom_height);
    slot = pred_col >> 1;
    pair = '0;
    // even rows sample chroma at even columns, odd rows read the line buffer
    if (pred_row % 2 == 0) begin
      if (pred_col % 2 == 0) begin
        pred_hold = {cb, cr};
        if (slot < LINE_DEPTH) pred_line[slot] = pred_hold;
      end
      pair = pred_hold;
    end else if (slot < LINE_DEPTH) begin
      pair = pred_line[slot];
    end
    y_adj  = ((int'(y) - Y_FLOOR) * Y_GAIN) >>> 16;
    cb_adj = int'(pair[15:8]) - C_CENTER;
    cr_adj = int'(pair[7:0]) - C_CENTER;
    px.red   = clamp_byte(y_adj + ((cr_adj * CR_TO_R) >>> 16));
    px.green = clamp_byte(y_adj - ((cb_adj * CB_TO_G + cr_adj * CR_TO_G) >>> 16));
    px.blue  = clamp_byte(y_adj + ((cb_adj * CB_TO_B) >>> 16));
    // flipped address wraps modulo the address width
    addr = (h - 1 - pred_row) * geom_stride + pred_col * 3;
    px.addr = addr[ADDR_W-1:0];
    row_end = (pred_col + 1 >= w);
    px.frame_end = row_end && (pred_row + 1 >= h);
    if (row_end) begin
      pred_col = 0;
      pred_row = px.frame_end ? 0 : pred_row + 1;
    end else begin
      pred_col = pred_col + 1;
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_luma        <= y;
    in_chroma_blue <= cb;
    in_chroma_red  <= cr;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(predict_rgb_pixel(y, cb, cr));
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // stream pixels until the raster reaches the given position
  task automatic advance_to(input int unsigned row, input int unsigned col);
    while (!(pred_row == row && pred_col == col)) send_random_pixel();
  endtask

  // wait until every expected pixel has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  geom_width = value[FWIDTH_W-1:0];
      REG_FRAME_HEIGHT: geom_height = value[FHEIGHT_W-1:0];
      REG_ROW_STRIDE:   geom_stride = value[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  // a width change waits for a point where the odd row below only reads
  // line entries written on the current even row
  task automatic program_geometry(input int unsigned w, input int unsigned h,
                                  input int unsigned s, input bit touch_spare);
    int unsigned new_w;
    new_w = eff_width(w[FWIDTH_W-1:0]);
    if (new_w != eff_width(geom_width)) begin
      while (!(pred_row % 2 == 0 && (pred_col == 0 || pred_col + 1 >= new_w)))
        send_random_pixel();
    end
    drain();
    write_reg(REG_FRAME_WIDTH, w[CFG_W-1:0]);
    write_reg(REG_FRAME_HEIGHT, h[CFG_W-1:0]);
    write_reg(REG_ROW_STRIDE, s[CFG_W-1:0]);
    if (touch_spare) write_reg(REG_SPARE, CFG_W'($urandom));
    cfg_we <= 1'b0;
    geometries++;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // random back-pressure, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // compare each accepted result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    rgb_pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none actual rgb %0h %0h %0h addr 0x%0h",
                 $time, out_red, out_green, out_blue, out_byte_address);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("byte_address", want.addr, out_byte_address);
        check_field("frame_end", want.frame_end, out_frame_end);
        pixels_checked++;
        if (out_frame_end) frames_seen++;
      end
    end
  end

  // watchdog and input stall count
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && !in_ready) input_stall_cycles++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels outstanding", $time, expected_pixels.size());
      $display("ycbcr420_to_rgb_flip verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset geometry: 640 wide, 480 high, 1920 byte stride
  task automatic test_reset_geometry();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'hAA, 8'h55);
    send_pixel(8'd16, 8'd128, 8'd128);
  endtask

  // channel clamps, chroma reuse on odd columns and odd rows, ignored chroma
  task automatic test_color_extremes();
    program_geometry(4, 2, 12, 1'b0);
    advance_to(0, 0);
    // row 0: chroma on even columns only
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd16, 8'd0, 8'd0);
    // row 1: chroma inputs ignored, line buffer used
    send_pixel(8'd235, 8'd77, 8'd200);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd128, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd128);
    // mixed chroma extremes and a saturated red
    send_pixel(8'd128, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd9, 8'd9);
    send_pixel(8'd81, 8'd90, 8'd240);
    send_pixel(8'd235, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd16, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd0, 8'd0);
  endtask

  // zero and oversize registers clamp, stride extremes, spare register index
  task automatic test_size_clamps();
    program_geometry(0, 0, 3, 1'b1);
    repeat (3) send_random_pixel();
    program_geometry(2048, 2048, 6144, 1'b0);
    repeat (4) send_random_pixel();
    program_geometry(4095, 4095, 8191, 1'b1);
    repeat (4) send_random_pixel();
    program_geometry(3, 2, 0, 1'b0);
    advance_to(0, 0);
  endtask

  // geometry changes with the frame part done
  task automatic test_midframe_changes();
    program_geometry(4, 4, 12, 1'b0);
    advance_to(2, 1);
    // current row now past the last one: address wraps
    program_geometry(4, 1, 5000, 1'b0);
    advance_to(0, 0);
    program_geometry(4, 4, 12, 1'b0);
    advance_to(2, 0);
    // wider rows from the start of an even row
    program_geometry(6, 4, 20, 1'b0);
    advance_to(0, 0);
  endtask

  // random geometry, mostly small frames with an occasional wide row
  task automatic test_random_stream(input int src_pct, input int sink_pct, input int count);
    int target;
    int unsigned w;
    int unsigned h;
    int unsigned s;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    target = pixels_sent + count;
    while (pixels_sent < target) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(300, 25) : $urandom_range(24);
      h = ($urandom_range(19) == 0) ? 0 : $urandom_range(6, 1);
      s = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(6144, 3);
      program_geometry(w, h, s, 1'b0);
      repeat ($urandom_range(80, 10)) send_random_pixel();
    end
  endtask

  // long output hold-off while the input keeps offering pixels
  task automatic test_output_stall();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    program_geometry(16, 4, 48, 1'b0);
    hold_req <= hold_req + 1;
    repeat (40) send_random_pixel();
    drain();
  endtask

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) pred_line[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_geometry();
    test_color_extremes();
    test_size_clamps();
    test_midframe_changes();
    test_random_stream(31, 46, 150);
    test_random_stream(46, 31, 150);
    test_random_stream(0, 0, 150);
    test_output_stall();

    drain();
    repeat (8) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d pixels never came out", $time, expected_pixels.size());
      errors += expected_pixels.size();
    end
    $display("checked %0d of %0d pixels over %0d geometry settings, %0d frame ends",
             pixels_checked, pixels_sent, geometries, frames_seen);
    $display("input held off for %0d cycles, %0d mismatches", input_stall_cycles, errors);
    if (errors == 0) begin
      $display("ycbcr420_to_rgb_flip verification clean");
    end else begin
      $display("ycbcr420_to_rgb_flip verification failed");
    end
    $finish;
  end

endmodule
